/* hw/rtl/mfi_pkg.sv */
package mfi_pkg;

    localparam int ACC_W      = 64;
    localparam int PERIOD_W   = 11;
    localparam int BARS_W     = 11;
    localparam int MFI_W      = 23;
    localparam int INT_BITS   = 7;
    localparam int CNT_W      = 7;
    localparam int SM_ITERS   = 64;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd14;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 11'd2;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 11'd1024;
    localparam logic [BARS_W-1:0]   BARS_MAX     = 11'd2047;

    localparam int PRICE_BITS_DEF    = 28;
    localparam int VOLUME_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [1:0] OSEL_RATIO = 2'd0;
    localparam logic [1:0] OSEL_FULL  = 2'd1;
    localparam logic [1:0] OSEL_ZERO  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul;
        logic       warm_add;
        logic       sm_init;
        logic       sm_step;
        logic       sm_write;
        logic       rt_init;
        logic       rt_step;
        logic       out_load;
        logic [1:0] out_sel;
    } mfi_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic warm;
        logic first;
        logic up;
        logic down;
        logic pos_zero;
        logic neg_zero;
    } mfi_sts_t;

endpackage

/* hw/rtl/mfi_ctrl.sv */
module mfi_ctrl
    import mfi_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  mfi_sts_t sts,
    output mfi_cmd_t cmd
);

    localparam int Q_W = INT_BITS + FRACTION_BITS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_MUL     = 4'd1;
    localparam logic [3:0] S_DECIDE  = 4'd2;
    localparam logic [3:0] S_SM_INIT = 4'd3;
    localparam logic [3:0] S_SM_RUN  = 4'd4;
    localparam logic [3:0] S_SM_WR   = 4'd5;
    localparam logic [3:0] S_VALUE   = 4'd6;
    localparam logic [3:0] S_RT_INIT = 4'd7;
    localparam logic [3:0] S_RT_RUN  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]       osel_reg, osel_next;
    logic             ovalid_reg, ovalid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        osel_next   = osel_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd         = '0;
        cmd.out_sel = osel_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (sts.n_zero)
                    state_next = S_IDLE;
                else if (sts.warm)
                begin
                    cmd.warm_add = 1'b1;
                    state_next   = sts.first ? S_VALUE : S_IDLE;
                end
                else if (sts.up || sts.down)
                    state_next = S_SM_INIT;
                else
                    state_next = S_VALUE;
            end
            S_SM_INIT:
            begin
                cmd.sm_init = 1'b1;
                cnt_next    = '0;
                state_next  = S_SM_RUN;
            end
            S_SM_RUN:
            begin
                cmd.sm_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SM_ITERS - 1))
                    state_next = S_SM_WR;
            end
            S_SM_WR:
            begin
                cmd.sm_write = 1'b1;
                state_next   = S_VALUE;
            end
            S_VALUE:
            begin
                if (!sts.neg_zero)
                    state_next = S_RT_INIT;
                else
                begin
                    state_next = S_OUT;
                    if (!sts.first && sts.pos_zero)
                        osel_next = OSEL_ZERO;
                    else
                        osel_next = OSEL_FULL;
                end
            end
            S_RT_INIT:
            begin
                cmd.rt_init = 1'b1;
                cnt_next    = '0;
                state_next  = S_RT_RUN;
            end
            S_RT_RUN:
            begin
                cmd.rt_step = 1'b1;
                cnt_next    = cnt_reg + 1'b1;
                osel_next   = OSEL_RATIO;
                if (cnt_reg == CNT_W'(Q_W - 1))
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            osel_reg   <= OSEL_RATIO;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            osel_reg   <= osel_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

/* hw/rtl/mfi_dp.sv */
module mfi_dp
    import mfi_pkg::*;
#(
    parameter int PRICE_BITS    = PRICE_BITS_DEF,
    parameter int VOLUME_BITS   = VOLUME_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   period_write,
    input  logic [PERIOD_W-1:0]    period_data,
    input  logic                   series_start,
    input  logic [PRICE_BITS-1:0]  bar_high,
    input  logic [PRICE_BITS-1:0]  bar_low,
    input  logic [PRICE_BITS-1:0]  bar_close,
    input  logic [VOLUME_BITS-1:0] bar_volume,
    input  mfi_cmd_t               cmd,
    output mfi_sts_t               sts,
    output logic [MFI_W-1:0]       mfi_value,
    output logic                   first_value
);

    localparam int SUM_W  = PRICE_BITS + 2;
    localparam int FLOW_W = SUM_W + VOLUME_BITS;
    localparam int NUM_W  = ACC_W + PERIOD_W;
    localparam int Q_W    = INT_BITS + FRACTION_BITS;
    localparam int M_W    = ACC_W + INT_BITS;

    localparam logic [MFI_W-1:0] FULL_VALUE = MFI_W'(100 * (2 ** FRACTION_BITS));

    logic [PERIOD_W-1:0]    period_reg;
    logic [PERIOD_W-1:0]    p_reg;
    logic [SUM_W-1:0]       prev_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [VOLUME_BITS-1:0] vol_reg;
    logic [FLOW_W-1:0]      flow_reg;
    logic [BARS_W-1:0]      bars_reg;
    logic [BARS_W-1:0]      n_reg;
    logic                   up_reg, down_reg;
    logic [ACC_W-1:0]       pos_reg, neg_reg;

    logic [PERIOD_W-1:0]    sm_rem_pos_reg, sm_rem_neg_reg;
    logic [ACC_W-1:0]       sm_sh_pos_reg, sm_sh_neg_reg;
    logic [ACC_W:0]         rt_rem_reg;
    logic [ACC_W:0]         rt_d_reg;
    logic [Q_W-1:0]         rt_sh_reg;
    logic [MFI_W-1:0]       mfi_reg;
    logic                   first_reg;

    // input stage terms
    logic [SUM_W-1:0]    sum_in;
    logic [SUM_W-1:0]    prev_eff;
    logic [BARS_W-1:0]   n_eff;
    logic [PERIOD_W-1:0] p_clamp;

    assign sum_in   = SUM_W'(bar_high) + SUM_W'(bar_low) + SUM_W'(bar_close);
    assign prev_eff = series_start ? '0 : prev_reg;
    assign n_eff    = series_start ? '0 : bars_reg;

    always_comb
    begin
        priority if (period_reg < PERIOD_MIN)
            p_clamp = PERIOD_MIN;
        else if (period_reg > PERIOD_MAX)
            p_clamp = PERIOD_MAX;
        else
            p_clamp = period_reg;
    end

    // warm-up saturating sums
    logic [ACC_W:0] pos_add, neg_add;
    assign pos_add = {1'b0, pos_reg} + (ACC_W+1)'(flow_reg);
    assign neg_add = {1'b0, neg_reg} + (ACC_W+1)'(flow_reg);

    // smoothing numerators f*(p-1)+x
    logic [PERIOD_W-1:0] pm1;
    logic [NUM_W-1:0]    num_pos, num_neg;
    logic [FLOW_W-1:0]   x_pos, x_neg;
    assign pm1     = p_reg - 1'b1;
    assign x_pos   = up_reg ? flow_reg : '0;
    assign x_neg   = down_reg ? flow_reg : '0;
    assign num_pos = NUM_W'(pos_reg) * NUM_W'(pm1) + NUM_W'(x_pos);
    assign num_neg = NUM_W'(neg_reg) * NUM_W'(pm1) + NUM_W'(x_neg);

    // one restoring step per lane
    logic [PERIOD_W:0] sm_try_pos, sm_try_neg;
    logic              sm_bit_pos, sm_bit_neg;
    assign sm_try_pos = {sm_rem_pos_reg, sm_sh_pos_reg[ACC_W-1]};
    assign sm_try_neg = {sm_rem_neg_reg, sm_sh_neg_reg[ACC_W-1]};
    assign sm_bit_pos = (sm_try_pos >= {1'b0, p_reg});
    assign sm_bit_neg = (sm_try_neg >= {1'b0, p_reg});

    // ratio: pos*100 and its restoring step
    logic [M_W-1:0]   m100;
    logic [ACC_W+1:0] rt_try;
    logic             rt_bit;
    assign m100   = {pos_reg, 7'b0} - {pos_reg, 5'b0} + {pos_reg, 2'b0};
    assign rt_try = {rt_rem_reg, rt_sh_reg[Q_W-1]};
    assign rt_bit = (rt_try >= {1'b0, rt_d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
            prev_reg   <= '0;
            bars_reg   <= '0;
            pos_reg    <= '0;
            neg_reg    <= '0;
        end
        else
        begin
            if (period_write)
                period_reg <= period_data;
            if (cmd.load)
            begin
                prev_reg <= sum_in;
                bars_reg <= (n_eff == BARS_MAX) ? BARS_MAX : n_eff + 1'b1;
                if (series_start)
                begin
                    pos_reg <= '0;
                    neg_reg <= '0;
                end
            end
            if (cmd.warm_add)
            begin
                if (up_reg)
                    pos_reg <= pos_add[ACC_W] ? '1 : pos_add[ACC_W-1:0];
                if (down_reg)
                    neg_reg <= neg_add[ACC_W] ? '1 : neg_add[ACC_W-1:0];
            end
            if (cmd.sm_write)
            begin
                pos_reg <= sm_sh_pos_reg;
                neg_reg <= sm_sh_neg_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sum_reg  <= sum_in;
            vol_reg  <= bar_volume;
            n_reg    <= n_eff;
            p_reg    <= p_clamp;
            up_reg   <= (sum_in > prev_eff);
            down_reg <= (sum_in < prev_eff);
        end
        if (cmd.mul)
            flow_reg <= FLOW_W'(sum_reg) * FLOW_W'(vol_reg);
        if (cmd.sm_init)
        begin
            sm_rem_pos_reg <= num_pos[NUM_W-1:ACC_W];
            sm_rem_neg_reg <= num_neg[NUM_W-1:ACC_W];
            sm_sh_pos_reg  <= num_pos[ACC_W-1:0];
            sm_sh_neg_reg  <= num_neg[ACC_W-1:0];
        end
        if (cmd.sm_step)
        begin
            sm_rem_pos_reg <= sm_bit_pos ? PERIOD_W'(sm_try_pos - {1'b0, p_reg})
                                         : sm_try_pos[PERIOD_W-1:0];
            sm_rem_neg_reg <= sm_bit_neg ? PERIOD_W'(sm_try_neg - {1'b0, p_reg})
                                         : sm_try_neg[PERIOD_W-1:0];
            sm_sh_pos_reg  <= {sm_sh_pos_reg[ACC_W-2:0], sm_bit_pos};
            sm_sh_neg_reg  <= {sm_sh_neg_reg[ACC_W-2:0], sm_bit_neg};
        end
        if (cmd.rt_init)
        begin
            rt_rem_reg <= (ACC_W+1)'(m100[M_W-1:INT_BITS]);
            rt_sh_reg  <= {m100[INT_BITS-1:0], {FRACTION_BITS{1'b0}}};
            rt_d_reg   <= {1'b0, pos_reg} + {1'b0, neg_reg};
        end
        if (cmd.rt_step)
        begin
            rt_rem_reg <= rt_bit ? (ACC_W+1)'(rt_try - {1'b0, rt_d_reg})
                                 : rt_try[ACC_W:0];
            rt_sh_reg  <= {rt_sh_reg[Q_W-2:0], rt_bit};
        end
        if (cmd.out_load)
        begin
            first_reg <= n_reg == BARS_W'(p_reg - 1'b1);
            unique case (cmd.out_sel)
                OSEL_FULL:  mfi_reg <= FULL_VALUE;
                OSEL_ZERO:  mfi_reg <= '0;
                default:    mfi_reg <= MFI_W'({{MFI_W{1'b0}}, rt_sh_reg});
            endcase
        end
    end

    assign sts.n_zero   = (n_reg == '0);
    assign sts.warm     = (n_reg < BARS_W'(p_reg));
    assign sts.first    = (n_reg == BARS_W'(p_reg - 1'b1));
    assign sts.up       = up_reg;
    assign sts.down     = down_reg;
    assign sts.pos_zero = (pos_reg == '0);
    assign sts.neg_zero = (neg_reg == '0);

    assign mfi_value   = mfi_reg;
    assign first_value = first_reg;

endmodule

/* hw/rtl/money_flow_index_stream.sv */
// sequence: load, multiply and decide for a bar without result; a smoothed bar
//   adds a 64-step smoothing divide, then a 7+FRACTION_BITS-step ratio divide
// input: in_stall stays high until the previous bar is through, so a new bar
//   waits for the restoring divide steps of the one before it
// reset: period 14, previous price sum, flows and bar count zero, no result pending
module money_flow_index_stream
    import mfi_pkg::*;
#(
    parameter int PRICE_BITS    = PRICE_BITS_DEF,
    parameter int VOLUME_BITS   = VOLUME_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // period register write
    input  logic                   period_write,
    input  logic [PERIOD_W-1:0]    period_data,
    // bar transaction
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   series_start,
    input  logic [PRICE_BITS-1:0]  bar_high,
    input  logic [PRICE_BITS-1:0]  bar_low,
    input  logic [PRICE_BITS-1:0]  bar_close,
    input  logic [VOLUME_BITS-1:0] bar_volume,
    // index transaction
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [MFI_W-1:0]       mfi_value,
    output logic                   first_value
);

    mfi_cmd_t cmd;
    mfi_sts_t sts;

    // controller sequences load, multiply, smoothing divide, ratio divide, output
    mfi_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // datapath holds flows, divider registers and the output register
    mfi_dp #(
        .PRICE_BITS    (PRICE_BITS),
        .VOLUME_BITS   (VOLUME_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_write (period_write),
        .period_data  (period_data),
        .series_start (series_start),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_volume   (bar_volume),
        .cmd          (cmd),
        .sts          (sts),
        .mfi_value    (mfi_value),
        .first_value  (first_value)
    );

endmodule

/* tb/sv/money_flow_index_check.sv */
module money_flow_index_check
    import mfi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                period_write,
    input  logic [PERIOD_W-1:0] period_data,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                series_start,
    input  logic [27:0]         bar_high,
    input  logic [27:0]         bar_low,
    input  logic [27:0]         bar_close,
    input  logic [23:0]         bar_volume,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [MFI_W-1:0]    mfi_value,
    input  logic                first_value,
    output int                  failures,
    output int                  pending,
    output int                  bars_taken,
    output int                  index_count
);

    typedef struct packed {
        logic [MFI_W-1:0] value;
        logic             first;
    } index_t;

    localparam logic [63:0] FULL_SCALE = 64'd100 << FRACTION_BITS_DEF;
    localparam int          FIFO_DEPTH = 8;

    logic [PERIOD_W-1:0] period_reg;
    logic [29:0]         last_sum;
    logic [63:0]         pos_flow;
    logic [63:0]         neg_flow;
    logic [BARS_W-1:0]   bar_count;

    // expected index values in order of arrival
    index_t              index_fifo[FIFO_DEPTH];
    logic [2:0]          fifo_wr;
    logic [2:0]          fifo_rd;
    int                  fifo_fill;

    function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // (f*(p-1)+x)/p, clipped to 64 bits
    function automatic logic [63:0] smooth(logic [63:0] f, logic [63:0] x, logic [63:0] p);
        logic [127:0] q;
        q = ({64'd0, f} * (p - 1) + {64'd0, x}) / {64'd0, p};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] share(logic [63:0] pos, logic [63:0] neg);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        num = {64'd0, pos} * {64'd0, FULL_SCALE};
        den = {64'd0, pos} + {64'd0, neg};
        q = num / den;
        return q[63:0];
    endfunction

    // advance the bar state; returns 1 when an index value is due
    task automatic predict_bar(output bit emits, output index_t res);
        logic [63:0] p;
        logic [29:0] sum;
        logic [63:0] flow;
        logic [63:0] v;
        logic [BARS_W-1:0] n;
        bit up;
        bit down;
        p = 64'(period_reg);
        if (p < PERIOD_MIN) p = 64'(PERIOD_MIN);
        if (p > PERIOD_MAX) p = 64'(PERIOD_MAX);
        if (series_start)
        begin
            last_sum = '0;
            pos_flow = '0;
            neg_flow = '0;
            bar_count = '0;
        end
        sum = 30'(bar_high) + 30'(bar_low) + 30'(bar_close);
        flow = 64'(sum) * 64'(bar_volume);
        n = bar_count;
        up = sum > last_sum;
        down = sum < last_sum;
        last_sum = sum;
        if (bar_count < BARS_MAX) bar_count = bar_count + 1'b1;
        emits = 0;
        res = '0;
        if (n == 0) return;
        if (64'(n) < p)
        begin
            if (up) pos_flow = sat_add(pos_flow, flow);
            if (down) neg_flow = sat_add(neg_flow, flow);
            if (64'(n) != p - 1) return;
            res.first = 1'b1;
            v = (neg_flow == 0) ? FULL_SCALE : share(pos_flow, neg_flow);
        end
        else
        begin
            if (up)
            begin
                pos_flow = smooth(pos_flow, flow, p);
                neg_flow = smooth(neg_flow, 64'd0, p);
            end
            else if (down)
            begin
                neg_flow = smooth(neg_flow, flow, p);
                pos_flow = smooth(pos_flow, 64'd0, p);
            end
            if (neg_flow == 0) v = (pos_flow == 0) ? 64'd0 : FULL_SCALE;
            else v = share(pos_flow, neg_flow);
        end
        res.value = v[MFI_W-1:0];
        emits = 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bit     emits;
        index_t res;
        index_t want;
        if (!rst_n)
        begin
            period_reg = PERIOD_RESET;
            last_sum = '0;
            pos_flow = '0;
            neg_flow = '0;
            bar_count = '0;
            fifo_wr = '0;
            fifo_rd = '0;
            fifo_fill = 0;
            failures = 0;
            pending = 0;
            bars_taken = 0;
            index_count = 0;
        end
        else
        begin
            if (period_write) period_reg = period_data;
            if (in_valid && !in_stall)
            begin
                bars_taken++;
                predict_bar(emits, res);
                if (emits)
                begin
                    if (fifo_fill == FIFO_DEPTH)
                    begin
                        failures++;
                        $display("%0t: too many index values outstanding", $time);
                    end
                    else
                    begin
                        index_fifo[fifo_wr] = res;
                        fifo_wr = fifo_wr + 1'b1;
                        fifo_fill++;
                    end
                end
            end
            if (out_valid && !out_stall)
            begin
                index_count++;
                if (fifo_fill == 0)
                begin
                    failures++;
                    $display("%0t: expected no index value, got value %0d first %0b", $time,
                             mfi_value, first_value);
                end
                else
                begin
                    want = index_fifo[fifo_rd];
                    fifo_rd = fifo_rd + 1'b1;
                    fifo_fill--;
                    if (want.value !== mfi_value || want.first !== first_value)
                    begin
                        failures++;
                        $display("%0t: expected value %0d first %0b, got value %0d first %0b",
                                 $time, want.value, want.first, mfi_value, first_value);
                    end
                end
            end
            pending = fifo_fill;
        end
    end

endmodule

/* tb/sv/money_flow_index_stream_test.sv */
module money_flow_index_stream_test;
    import mfi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 120;
    localparam logic [27:0] PRICE_MAX  = '1;
    localparam logic [23:0] VOLUME_MAX = '1;

    logic                clk;
    logic                rst_n;
    logic                period_write;
    logic [PERIOD_W-1:0] period_data;
    logic                in_valid;
    logic                in_stall;
    logic                series_start;
    logic [27:0]         bar_high;
    logic [27:0]         bar_low;
    logic [27:0]         bar_close;
    logic [23:0]         bar_volume;
    logic                out_valid;
    logic                out_stall;
    logic [MFI_W-1:0]    mfi_value;
    logic                first_value;

    int failures;
    int pending;
    int bars_taken;
    int index_count;

    // idle percentages for the current phase
    int send_gap_pct;
    int recv_stall_pct;
    // long receiver hold-off request, served by the receiver process
    int hold_request;
    int idle_cycles;

    // last bar sent, used to build up, down and flat moves
    logic [27:0] prev_h;
    logic [27:0] prev_l;
    logic [27:0] prev_c;

    money_flow_index_stream uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_write (period_write),
        .period_data  (period_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .series_start (series_start),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_volume   (bar_volume),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mfi_value    (mfi_value),
        .first_value  (first_value)
    );

    money_flow_index_check checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .period_write (period_write),
        .period_data  (period_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .series_start (series_start),
        .bar_high     (bar_high),
        .bar_low      (bar_low),
        .bar_close    (bar_close),
        .bar_volume   (bar_volume),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .mfi_value    (mfi_value),
        .first_value  (first_value),
        .failures     (failures),
        .pending      (pending),
        .bars_taken   (bars_taken),
        .index_count  (index_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stall, or a long counted hold-off on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_request <= hold_request - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog: any cycle without a transaction on either channel counts
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // one bar transaction; entered and left just after a falling edge
    task automatic send_bar(input logic start, input logic [27:0] h, input logic [27:0] l,
                            input logic [27:0] c, input logic [23:0] v);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        series_start <= start;
        bar_high     <= h;
        bar_low      <= l;
        bar_close    <= c;
        bar_volume   <= v;
        prev_h = h;
        prev_l = l;
        prev_c = c;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // waits out every expected index value plus the block's longest bar
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        period_write <= 1'b1;
        period_data  <= value;
        @(negedge clk);
        period_write <= 1'b0;
    endtask

    function automatic logic [27:0] nudge(input logic [27:0] x);
        int d;
        d = $urandom_range(8) - 4;
        return x + 28'(d);
    endfunction

    // random bar: mostly small moves so both sides of the flow get credit
    task automatic random_bar();
        logic [27:0] h;
        logic [27:0] l;
        logic [27:0] c;
        logic [23:0] v;
        logic        start;
        int          mode;
        mode = $urandom_range(99);
        start = ($urandom_range(99) < 2);
        if (mode < 15)
        begin
            h = 28'($urandom);
            l = 28'($urandom);
            c = 28'($urandom);
        end
        else if (mode < 80)
        begin
            h = nudge(prev_h);
            l = nudge(prev_l);
            c = nudge(prev_c);
        end
        else if (mode < 92)
        begin
            // flat bar: same price sum as before
            h = prev_h;
            l = prev_l;
            c = prev_c;
        end
        else
        begin
            h = $urandom_range(1) ? PRICE_MAX : '0;
            l = $urandom_range(1) ? PRICE_MAX : '0;
            c = $urandom_range(1) ? PRICE_MAX : '0;
        end
        case ($urandom_range(9))
            0: v = '0;
            1: v = VOLUME_MAX;
            2, 3, 4: v = 24'($urandom);
            default: v = 24'($urandom_range(1000));
        endcase
        send_bar(start, h, l, c, v);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:
            begin
                send_gap_pct = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_gap_pct = 48;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_gap_pct = 0;
                recv_stall_pct = 48;
            end
            default:
            begin
                send_gap_pct = 6;
                recv_stall_pct = 6;
            end
        endcase
    endtask

    initial
    begin
        // period settings per phase; out of range values test the clamp
        logic [PERIOD_W-1:0] periods[9];
        int                  counts[9];
        int                  i;
        int                  k;
        periods = '{11'd2, 11'd5, 11'd0, 11'd1, 11'd20, 11'd1024, 11'd2047, 11'd3, 11'd14};
        counts  = '{250, 250, 150, 150, 250, 180, 100, 300, 300};
        rst_n = 1'b0;
        period_write = 1'b0;
        period_data = '0;
        in_valid = 1'b0;
        series_start = 1'b0;
        bar_high = '0;
        bar_low = '0;
        bar_close = '0;
        bar_volume = '0;
        out_stall = 1'b0;
        hold_request = 0;
        idle_cycles = 0;
        prev_h = '0;
        prev_l = '0;
        prev_c = '0;
        set_idling(0);
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part at period 3: flat, up, down, extremes, restart
        write_period(11'd3);
        send_bar(1'b1, 28'd100, 28'd100, 28'd100, 24'd7);
        send_bar(1'b0, 28'd100, 28'd100, 28'd100, 24'd7);   // flat, still warming up
        send_bar(1'b0, 28'd100, 28'd100, 28'd100, 24'd7);   // first value, both flows zero
        send_bar(1'b0, 28'd100, 28'd100, 28'd100, 24'd7);   // later value, both zero
        send_bar(1'b0, 28'd101, 28'd100, 28'd100, 24'd9);   // up only
        send_bar(1'b0, 28'd50, 28'd50, 28'd50, 24'd3);      // down
        send_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX);
        send_bar(1'b0, '0, '0, '0, VOLUME_MAX);
        send_bar(1'b0, PRICE_MAX, '0, PRICE_MAX, '0);        // zero volume move
        send_bar(1'b1, 28'd10, 28'd10, 28'd10, 24'd1);      // restart the series
        send_bar(1'b0, 28'd9, 28'd9, 28'd9, 24'd1);         // down only
        send_bar(1'b0, 28'd20, 28'd9, 28'd9, VOLUME_MAX);   // first value
        send_bar(1'b1, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX);
        send_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX - 1'b1, VOLUME_MAX);
        send_bar(1'b0, PRICE_MAX, PRICE_MAX, PRICE_MAX, VOLUME_MAX);
        settle();

        // random phases; the period changes mid-series on purpose
        for (i = 0; i < 9; i++)
        begin
            write_period(periods[i]);
            set_idling(i % 4);
            if (i == 2) hold_request = 400;
            for (k = 0; k < counts[i]; k++) random_bar();
            settle();
        end

        $display("covered %0d bars and %0d index values over %0d period settings",
                 bars_taken, index_count, 10);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
